@@ sv/ring_fifo_overwrite_peek_assert.svh @@
// Assertion macros for the ring FIFO block.
`ifndef RING_FIFO_OVERWRITE_PEEK_ASSERT_SVH
`define RING_FIFO_OVERWRITE_PEEK_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define RFOP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RFOP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/rfop_pkg.sv @@
// Shared constants and operation codes of the ring FIFO block.
`default_nettype none

package rfop_pkg;

	localparam int DEPTH_DEF      = 256;
	localparam int ITEM_WIDTH_DEF = 32;

	localparam int CAP_W    = 9;
	localparam int FUNC_W   = 3;
	localparam int DATA_W   = 32;
	localparam int AMOUNT_W = 9;
	localparam int DONE_W   = 8;
	localparam int LEVEL_W  = 8;

	// Capacity after reset, before any register write
	localparam int CAP_RESET_LIMIT = 256;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH      = 3'd0,
		FUNC_OVERWRITE = 3'd1,
		FUNC_POP       = 3'd2,
		FUNC_REMOVE    = 3'd3,
		FUNC_PEEK      = 3'd4
	} func_t;

endpackage

`default_nettype wire

@@ sv/rfop_if.sv @@
// Valid/ready channel interfaces for the ring FIFO operation and result items.
`default_nettype none

interface rfop_in_if import rfop_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [DATA_W-1:0]   write_data;
	logic [AMOUNT_W-1:0] amount;

	modport source (output valid, output func, output write_data, output amount,
		input ready);
	modport sink (input valid, input func, input write_data, input amount,
		output ready);
endinterface

interface rfop_out_if import rfop_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               ok;
	logic [DATA_W-1:0]  read_data;
	logic [DONE_W-1:0]  amount_done;
	logic               dropped_oldest;
	logic [LEVEL_W-1:0] level;
	logic               full_res;
	logic               empty_res;

	modport source (output valid, output ok, output read_data, output amount_done,
		output dropped_oldest, output level, output full_res, output empty_res,
		input ready);
	modport sink (input valid, input ok, input read_data, input amount_done,
		input dropped_oldest, input level, input full_res, input empty_res,
		output ready);
endinterface

`default_nettype wire

@@ sv/ring_fifo_overwrite_peek.sv @@
// Ring FIFO with push, overwrite push, pop, bulk remove and peek at an offset.
// One operation item is taken per clock cycle while the result register is free
// or being taken; each item is registered in the input stage, then the pointer
// update, the single write and the single registered read of the item store all
// happen at the edge that moves it into the result register. Back-to-back items
// need no bypass since a write lands in the store at the edge that processes its
// item, before any following item reads it. The ring uses capacity_entries slots
// and keeps one free, so it holds up to capacity_entries - 1 items; writing the
// register empties the ring and must only happen while no item is in flight.
// The store is not cleared at reset; no entry is returned before it is written.
`default_nettype none

module ring_fifo_overwrite_peek import rfop_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CAP_W-1:0] cfg_wr_data,
	rfop_in_if.sink               in_ch,
	rfop_out_if.source            out_ch
);

	`include "ring_fifo_overwrite_peek_assert.svh"

	localparam int CAP_LIMIT = (2 ** CAP_W) - 1;
	localparam int CAP_MAX   = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;
	localparam int CAP_RST   = (DEPTH < CAP_RESET_LIMIT) ? DEPTH : CAP_RESET_LIMIT;
	localparam int IW        = $clog2(CAP_MAX);
	localparam int CW        = $clog2(CAP_MAX + 1);
	localparam int AW        = CAP_W + 1;
	localparam int SW        = (ITEM_WIDTH < DATA_W) ? ITEM_WIDTH : DATA_W;

	// State
	logic [CW-1:0] cap_q;
	logic [IW-1:0] wr_ptr_q;
	logic [IW-1:0] rd_ptr_q;
	logic [SW-1:0] mem [CAP_MAX];
	logic [SW-1:0] rdata_q;

	// Input stage
	logic                valid_s1;
	logic [FUNC_W-1:0]   func_s1;
	logic [DATA_W-1:0]   data_s1;
	logic [AMOUNT_W-1:0] amount_s1;

	// Result stage
	logic          valid_s2;
	logic          ok_s2;
	logic          rd_sel_s2;
	logic [CW-1:0] done_s2;
	logic          dropped_s2;
	logic [CW-1:0] level_s2;
	logic          full_s2;
	logic          empty_s2;

	logic          advance;
	logic          process;
	logic [CW-1:0] cfg_cap;

	logic [AW-1:0] wr_ext;
	logic [AW-1:0] rd_ext;
	logic [AW-1:0] cap_ext;
	logic [AW-1:0] amount_ext;
	logic [CW-1:0] level_now;
	logic [CW-1:0] peek_lim;
	logic [CW-1:0] rem_n;
	logic [CW-1:0] peek_n;
	logic          full_now;
	logic          empty_now;

	logic [IW-1:0] wr_nx;
	logic [IW-1:0] rd_nx;
	logic [IW-1:0] raddr;
	logic          mem_we;
	logic          ok_nx;
	logic          rd_sel_nx;
	logic [CW-1:0] done_nx;
	logic          dropped_nx;
	logic [CW-1:0] level_nx;
	logic          full_nx;
	logic          empty_nx;

	// Step an index by one slot, wrapping at the capacity
	function automatic logic [IW-1:0] adv_ptr(input logic [IW-1:0] p,
		input logic [CW-1:0] c);
		logic [AW-1:0] nx;
		nx = AW'(p) + AW'(1);
		return (nx >= AW'(c)) ? '0 : IW'(nx);
	endfunction

	// Add an offset below the capacity to an index, wrapping once
	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] p,
		input logic [CW-1:0] n, input logic [CW-1:0] c);
		logic [AW-1:0] sum;
		sum = AW'(p) + AW'(n);
		if (sum >= AW'(c)) begin
			sum = sum - AW'(c);
		end
		return IW'(sum);
	endfunction

	// Move a result out whenever the result register is free or being taken
	assign advance     = !valid_s2 || out_ch.ready;
	assign process     = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;

	// Clamp a written capacity into the supported range
	always_comb begin
		if (cfg_wr_data == '0) begin
			cfg_cap = CW'(1);
		end else if (cfg_wr_data > CAP_W'(CAP_MAX)) begin
			cfg_cap = CW'(CAP_MAX);
		end else begin
			cfg_cap = CW'(cfg_wr_data);
		end
	end

	// Derive fill level, full and empty from the pointers
	always_comb begin
		wr_ext     = AW'(wr_ptr_q);
		rd_ext     = AW'(rd_ptr_q);
		cap_ext    = AW'(cap_q);
		amount_ext = AW'(amount_s1);
		if (wr_ext >= rd_ext) begin
			level_now = CW'(wr_ext - rd_ext);
		end else begin
			level_now = CW'(wr_ext + cap_ext - rd_ext);
		end
		full_now  = (adv_ptr(wr_ptr_q, cap_q) == rd_ptr_q);
		empty_now = (wr_ptr_q == rd_ptr_q);
		peek_lim  = level_now - CW'(1);
		rem_n     = (amount_ext < AW'(level_now)) ? CW'(amount_s1) : level_now;
		peek_n    = (amount_ext < AW'(peek_lim)) ? CW'(amount_s1) : peek_lim;
	end

	// Decode the operation held in the input stage
	always_comb begin
		wr_nx      = wr_ptr_q;
		rd_nx      = rd_ptr_q;
		raddr      = rd_ptr_q;
		mem_we     = 1'b0;
		ok_nx      = 1'b0;
		rd_sel_nx  = 1'b0;
		done_nx    = '0;
		dropped_nx = 1'b0;
		level_nx   = level_now;
		unique case (func_t'(func_s1))
			FUNC_PUSH: begin
				if (!full_now) begin
					mem_we   = 1'b1;
					wr_nx    = adv_ptr(wr_ptr_q, cap_q);
					ok_nx    = 1'b1;
					level_nx = level_now + CW'(1);
				end
			end
			FUNC_OVERWRITE: begin
				mem_we = 1'b1;
				wr_nx  = adv_ptr(wr_ptr_q, cap_q);
				ok_nx  = 1'b1;
				if (full_now) begin
					// drop the oldest item to make room
					dropped_nx = !empty_now;
					rd_nx      = adv_ptr(rd_ptr_q, cap_q);
				end else begin
					level_nx = level_now + CW'(1);
				end
			end
			FUNC_POP: begin
				if (!empty_now) begin
					rd_sel_nx = 1'b1;
					rd_nx     = adv_ptr(rd_ptr_q, cap_q);
					ok_nx     = 1'b1;
					level_nx  = level_now - CW'(1);
				end
			end
			FUNC_REMOVE: begin
				rd_nx    = wrap_add(rd_ptr_q, rem_n, cap_q);
				done_nx  = rem_n;
				ok_nx    = 1'b1;
				level_nx = level_now - rem_n;
			end
			FUNC_PEEK: begin
				if (!empty_now) begin
					raddr     = wrap_add(rd_ptr_q, peek_n, cap_q);
					rd_sel_nx = 1'b1;
					done_nx   = peek_n;
					ok_nx     = 1'b1;
				end
			end
			default: begin
			end
		endcase
		full_nx  = (level_nx == cap_q - CW'(1));
		empty_nx = (level_nx == '0);
	end

	// Hold capacity, pointers and stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CW'(CAP_RST);
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q    <= cfg_cap;
				wr_ptr_q <= '0;
				rd_ptr_q <= '0;
			end else if (process) begin
				wr_ptr_q <= wr_nx;
				rd_ptr_q <= rd_nx;
			end
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture the incoming item
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			func_s1   <= in_ch.func;
			data_s1   <= in_ch.write_data;
			amount_s1 <= in_ch.amount;
		end
	end

	// Capture the result fields
	always_ff @(posedge clk) begin
		if (process) begin
			ok_s2      <= ok_nx;
			rd_sel_s2  <= rd_sel_nx;
			done_s2    <= done_nx;
			dropped_s2 <= dropped_nx;
			level_s2   <= level_nx;
			full_s2    <= full_nx;
			empty_s2   <= empty_nx;
		end
	end

	// Item store: at most one write and one registered read per processed item
	always_ff @(posedge clk) begin
		if (process && mem_we) begin
			mem[wr_ptr_q] <= SW'(data_s1);
		end
		if (process) begin
			rdata_q <= mem[raddr];
		end
	end

	// Drive the result channel
	assign out_ch.valid          = valid_s2;
	assign out_ch.ok             = ok_s2;
	assign out_ch.read_data      = rd_sel_s2 ? DATA_W'(rdata_q) : '0;
	assign out_ch.amount_done    = DONE_W'(done_s2);
	assign out_ch.dropped_oldest = dropped_s2;
	assign out_ch.level          = LEVEL_W'(level_s2);
	assign out_ch.full_res       = full_s2;
	assign out_ch.empty_res      = empty_s2;

	`RFOP_ASSERT(a_ptr_in_ring, (CW'(wr_ptr_q) < cap_q) && (CW'(rd_ptr_q) < cap_q), "pointer beyond capacity")
	`RFOP_ASSERT(a_cfg_clears, cfg_wr_en |=> (wr_ptr_q == '0) && (rd_ptr_q == '0), "capacity write did not empty ring")
	`RFOP_ASSERT(a_result_follows, process |=> valid_s2, "processed item produced no result")

endmodule

`default_nettype wire
